// ----- sv/gn3_pkg.sv -----
`default_nettype none
package gn3_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 24;
  localparam int OUT_W         = 18;
  localparam int OUT_FRAC      = 16;
  localparam int OUT_MAX       = 131071;
  localparam int OUT_MIN       = -131072;
  localparam int LATENCY       = 9;

  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
    8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
    8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
    8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
    8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
    8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
    8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
    8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
    8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
    8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
    8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
    8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
    8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
    8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
    8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
    8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
    8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
    8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
    8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
    8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

  function automatic logic [7:0] perm(input logic [7:0] idx);
    return PERM[idx];
  endfunction

endpackage
`default_nettype wire

// ----- sv/gn3_lerp.sv -----
`default_nettype none
module gn3_lerp #(
  parameter int F = gn3_pkg::FRAC_BITS_DEF,
  parameter int W = gn3_pkg::FRAC_BITS_DEF + 3
) (
  input  wire logic                clk_i,
  input  wire logic [F:0]          w_i,
  input  wire logic signed [W-1:0] a_i,
  input  wire logic signed [W-1:0] b_i,
  output logic signed [W-1:0]      y_o
);
  localparam int PW = W + F + 3;
  localparam logic signed [PW-1:0] RND = PW'(1) <<< (F - 1);

  logic signed [W:0]    diff;
  logic signed [PW-1:0] prod;
  logic signed [W-1:0]  y_d, y_q;

  always_comb begin
    diff = (W+1)'(a_i) - (W+1)'(b_i);
    diff = -diff;
    prod = PW'(diff) * PW'($signed({1'b0, w_i})) + RND;
    y_d  = a_i + W'(prod >>> F);
  end

  always_ff @(posedge clk_i) begin
    y_q <= y_d;
  end

  assign y_o = y_q;
endmodule
`default_nettype wire

// ----- sv/gradient_noise_3d_top.sv -----
// Improved 3D gradient noise, fully pipelined.
// The result strobe is the last bit of the vld_q valid shift register, aligned with the registered result.
// Throughput: one point per cycle; busy_o is always low.
// Fade uses one multiplier per axis per stage; hashes read the permutation ROM in three stages.
// Reset (async, active low) clears the valid pipeline; data registers are not reset.
`default_nettype none
module gradient_noise_3d_top #(
  parameter int FRAC_BITS = gn3_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic signed [gn3_pkg::COORD_W-1:0] x_coord_i,
  input  wire logic signed [gn3_pkg::COORD_W-1:0] y_coord_i,
  input  wire logic signed [gn3_pkg::COORD_W-1:0] z_coord_i,
  output logic                                  noise_valid_o,
  output logic signed [gn3_pkg::OUT_W-1:0]      noise_value_o
);
  import gn3_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 6;
  localparam int PW  = 2 * AW;
  localparam int GW  = F + 3;
  localparam int SHR = (F > OUT_FRAC) ? F - OUT_FRAC : 0;
  localparam int SHL = (F < OUT_FRAC) ? OUT_FRAC - F : 0;
  localparam int EW  = GW + SHL + 1;
  localparam logic signed [AW-1:0] ONE_A = AW'(1) <<< F;
  localparam logic signed [GW-1:0] ONE_G = GW'(1) <<< F;
  localparam logic signed [PW-1:0] RND   = PW'(1) <<< (F - 1);
  localparam logic signed [EW-1:0] RND_O = EW'((1 << SHR) >> 1);
  localparam logic signed [EW-1:0] MAX_E = EW'(OUT_MAX);
  localparam logic signed [EW-1:0] MIN_E = EW'(OUT_MIN);

  function automatic logic signed [AW-1:0] fmul(input logic signed [AW-1:0] a,
                                                input logic signed [AW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b) + RND;
    return AW'(p >>> F);
  endfunction

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                input logic signed [GW-1:0] x,
                                                input logic signed [GW-1:0] y,
                                                input logic signed [GW-1:0] z);
    logic signed [GW-1:0] u, v;
    u = h[3] ? y : x;
    v = (h[3:2] == 2'b00) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  logic [LATENCY-1:0] vld_q;

  logic [F-1:0]          t1_q [3], t2_q [3], t3_q [3], t4_q [3];
  logic signed [AW-1:0]  acc0_d [3], acc1_d [3], acc2_d [3], acc3_d [3], fade_d [3];
  logic signed [AW-1:0]  acc0_q [3], acc1_q [3], acc2_q [3], acc3_q [3];
  logic [F:0]            f5_q [3];
  logic [F:0]            fv6_q, fw6_q, fw7_q;
  logic [7:0]            pa1_q, pb1_q, cz1_q;
  logic [7:0]            aa2_q, ab2_q, ba2_q, bb2_q;
  logic signed [GW-1:0]  g_d [8], g3_q [8], g4_q [8], g5_q [8];
  logic signed [GW-1:0]  lx [4], ly [2], lz;
  logic [7:0]            cell_idx [3];
  logic [F-1:0]          frac [3];
  logic signed [GW-1:0]  p0 [3], p1 [3];
  logic signed [EW-1:0]  r_e, r_s;
  logic signed [OUT_W-1:0] out_d, out_q;

  always_comb begin
    logic signed [COORD_W-1:0] c [3];
    logic [31:0] ext;
    logic [7:0] hv [8];
    c[0] = x_coord_i;
    c[1] = y_coord_i;
    c[2] = z_coord_i;
    for (int k = 0; k < 3; k++) begin
      ext         = {{8{c[k][COORD_W-1]}}, c[k]};
      cell_idx[k] = ext[F+7 -: 8];
      frac[k]     = c[k][F-1:0];
      acc0_d[k]   = AW'(6) * AW'(frac[k]) - AW'(15) * ONE_A;
      acc1_d[k]   = fmul(acc0_q[k], AW'(t1_q[k])) + AW'(10) * ONE_A;
      acc2_d[k]   = fmul(acc1_q[k], AW'(t2_q[k]));
      acc3_d[k]   = fmul(acc2_q[k], AW'(t3_q[k]));
      fade_d[k]   = fmul(acc3_q[k], AW'(t4_q[k]));
      p0[k]       = GW'(t2_q[k]);
      p1[k]       = GW'(t2_q[k]) - ONE_G;
    end
    hv[0] = perm(aa2_q);
    hv[1] = perm(ba2_q);
    hv[2] = perm(ab2_q);
    hv[3] = perm(bb2_q);
    hv[4] = perm(aa2_q + 8'd1);
    hv[5] = perm(ba2_q + 8'd1);
    hv[6] = perm(ab2_q + 8'd1);
    hv[7] = perm(bb2_q + 8'd1);
    g_d[0] = grad(hv[0][3:0], p0[0], p0[1], p0[2]);
    g_d[1] = grad(hv[1][3:0], p1[0], p0[1], p0[2]);
    g_d[2] = grad(hv[2][3:0], p0[0], p1[1], p0[2]);
    g_d[3] = grad(hv[3][3:0], p1[0], p1[1], p0[2]);
    g_d[4] = grad(hv[4][3:0], p0[0], p0[1], p1[2]);
    g_d[5] = grad(hv[5][3:0], p1[0], p0[1], p1[2]);
    g_d[6] = grad(hv[6][3:0], p0[0], p1[1], p1[2]);
    g_d[7] = grad(hv[7][3:0], p1[0], p1[1], p1[2]);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      t1_q[k]   <= frac[k];
      acc0_q[k] <= acc0_d[k];
      t2_q[k]   <= t1_q[k];
      acc1_q[k] <= acc1_d[k];
      t3_q[k]   <= t2_q[k];
      acc2_q[k] <= acc2_d[k];
      t4_q[k]   <= t3_q[k];
      acc3_q[k] <= acc3_d[k];
      f5_q[k]   <= fade_d[k][F:0];
    end
    pa1_q <= perm(cell_idx[0]) + cell_idx[1];
    pb1_q <= perm(cell_idx[0] + 8'd1) + cell_idx[1];
    cz1_q <= cell_idx[2];
    aa2_q <= perm(pa1_q) + cz1_q;
    ab2_q <= perm(pa1_q + 8'd1) + cz1_q;
    ba2_q <= perm(pb1_q) + cz1_q;
    bb2_q <= perm(pb1_q + 8'd1) + cz1_q;
    for (int j = 0; j < 8; j++) begin
      g3_q[j] <= g_d[j];
      g4_q[j] <= g3_q[j];
      g5_q[j] <= g4_q[j];
    end
    fv6_q <= f5_q[1];
    fw6_q <= f5_q[2];
    fw7_q <= fw6_q;
    out_q <= out_d;
  end

  for (genvar j = 0; j < 4; j++) begin : g_lx
    gn3_lerp #(.F(F), .W(GW)) u_lerp (
      .clk_i (clk_i),
      .w_i   (f5_q[0]),
      .a_i   (g5_q[2*j]),
      .b_i   (g5_q[2*j+1]),
      .y_o   (lx[j])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_ly
    gn3_lerp #(.F(F), .W(GW)) u_lerp (
      .clk_i (clk_i),
      .w_i   (fv6_q),
      .a_i   (lx[2*j]),
      .b_i   (lx[2*j+1]),
      .y_o   (ly[j])
    );
  end

  gn3_lerp #(.F(F), .W(GW)) u_lerp_z (
    .clk_i (clk_i),
    .w_i   (fw7_q),
    .a_i   (ly[0]),
    .b_i   (ly[1]),
    .y_o   (lz)
  );

  always_comb begin
    r_e = EW'(lz);
    r_s = ((r_e + RND_O) >>> SHR) <<< SHL;
    priority if (r_s > MAX_E) begin
      out_d = OUT_W'(OUT_MAX);
    end else if (r_s < MIN_E) begin
      out_d = OUT_W'(OUT_MIN);
    end else begin
      out_d = r_s[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start_i};
    end
  end

  assign busy_o        = 1'b0;
  assign noise_valid_o = vld_q[LATENCY-1];
  assign noise_value_o = out_q;
endmodule
`default_nettype wire

// ----- sv/gn3_checker.sv -----
`default_nettype none
module gn3_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic noise_valid_o
);
  import gn3_pkg::*;

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LATENCY noise_valid_o)
    else $error("missing result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    noise_valid_o |-> $past(start_i, LATENCY))
    else $error("result without transaction");
endmodule

bind gradient_noise_3d_top gn3_checker u_gn3_checker (.*);
`default_nettype wire
